>>> design/varint_delta_codec_unit_defines.svh
// Assertion macros shared by the codec RTL
`ifndef VARINT_DELTA_CODEC_UNIT_DEFINES_SVH
`define VARINT_DELTA_CODEC_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define VDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("codec check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define VDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("codec check failed: next-cycle implication");

`endif

>>> design/vdc_pkg.sv
`timescale 1ns / 1ps

package vdc_pkg;

    // Word and digit geometry of the serial adder
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned DIGIT_W  = 8;
    localparam int unsigned N_DIGITS = WORD_W / DIGIT_W;
    localparam int unsigned DCNT_W   = $clog2(N_DIGITS);

    // Varint group format
    localparam int unsigned GROUP_W    = 7;
    localparam logic [2:0]  MAX_GROUPS = 3'd5;

    // Configuration register indexes
    localparam logic CFG_DECODE_MODE  = 1'b0;
    localparam logic CFG_DELTA_ENABLE = 1'b1;

    // Request to the serial adder
    typedef struct packed {
        logic start;
        logic sub;
    } add_req_t;

    // Status from the serial adder
    typedef struct packed {
        logic busy;
        logic done;
    } add_sts_t;

endpackage

>>> design/vdc_serial_add.sv
`timescale 1ns / 1ps

// Digit-serial adder/subtractor: one byte digit per cycle, LSB digit first.
module vdc_serial_add (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  vdc_pkg::add_req_t             req,
    input  logic [vdc_pkg::WORD_W-1:0]    op_a,
    input  logic [vdc_pkg::WORD_W-1:0]    op_b,
    output logic [vdc_pkg::WORD_W-1:0]    sum,
    output vdc_pkg::add_sts_t             sts
);

    logic [vdc_pkg::WORD_W-1:0]  a_reg, a_next;
    logic [vdc_pkg::WORD_W-1:0]  b_reg, b_next;
    logic [vdc_pkg::WORD_W-1:0]  sum_reg, sum_next;
    logic                        carry_reg, carry_next;
    logic [vdc_pkg::DCNT_W-1:0]  cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [vdc_pkg::DIGIT_W:0]   digit_sum;

    // Add the low digits of both shift registers with the running carry
    assign digit_sum = {1'b0, a_reg[vdc_pkg::DIGIT_W-1:0]}
                     + {1'b0, b_reg[vdc_pkg::DIGIT_W-1:0]}
                     + {{vdc_pkg::DIGIT_W{1'b0}}, carry_reg};

    always_comb begin
        a_next     = a_reg;
        b_next     = b_reg;
        sum_next   = sum_reg;
        carry_next = carry_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (req.start) begin
            // Load operands; subtract as a + ~b + 1
            a_next     = op_a;
            b_next     = req.sub ? ~op_b : op_b;
            carry_next = req.sub;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            // Shift one digit through, result enters from the top
            a_next     = a_reg >> vdc_pkg::DIGIT_W;
            b_next     = b_reg >> vdc_pkg::DIGIT_W;
            sum_next   = {digit_sum[vdc_pkg::DIGIT_W-1:0],
                          sum_reg[vdc_pkg::WORD_W-1:vdc_pkg::DIGIT_W]};
            carry_next = digit_sum[vdc_pkg::DIGIT_W];
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == vdc_pkg::DCNT_W'(vdc_pkg::N_DIGITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        sum_reg   <= sum_next;
        carry_reg <= carry_next;
    end

    assign sum      = sum_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

>>> design/varint_delta_codec_unit.sv
`timescale 1ns / 1ps
// Variable-byte integer codec for 32-bit values with optional delta coding. In encode
// mode (decode_mode = 0) each input beat on s_* yields one to five byte beats on m_*,
// seven bits each, least significant group first, bit 7 set on all but the last, which
// carries m_tlast. In decode mode one byte arrives per input beat; the byte with bit 7
// clear finishes the code and yields one value beat (m_tlast always set, m_tuser flags a
// code longer than five bytes). s_tuser starts a run and clears the delta base. The
// difference or sum runs through a byte-serial adder; the sequencer waits for its done
// strobe, moves the sum into a work register and then sends the result: in encode the
// n byte beats of the code, held back by output stalls, in decode the one value beat.
// A continuation byte in decode leaves the sequencer in idle, so input stays ready for
// the next byte. A finished beat waits in the output register while the next item is
// taken. Configuration writes go through cfg_wr_en / cfg_index / cfg_wdata and belong in
// idle periods only.
`include "varint_delta_codec_unit_defines.svh"

module varint_delta_codec_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic        cfg_wdata,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] in_data
    input  logic        s_tuser,   // [0] start_of_run
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] out_data
    output logic        m_tlast,
    output logic        m_tuser    // [0] overlong
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ARITH = 4'b0010,
        S_EMIT  = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t       state_reg, state_next;
    logic         decode_mode_reg, delta_en_reg;
    logic [31:0]  base_reg, base_next;
    logic [31:0]  acc_reg, acc_next;
    logic [2:0]   idx_reg, idx_next;
    logic         over_reg, over_next;
    logic         pend_over_reg, pend_over_next;
    logic [31:0]  work_reg, work_next;
    logic         m_valid_reg, m_valid_next;
    logic [31:0]  m_data_reg, m_data_next;
    logic         m_last_reg, m_last_next;
    logic         m_over_reg, m_over_next;

    vdc_pkg::add_req_t add_req;
    vdc_pkg::add_sts_t add_sts;
    logic [31:0]  add_a, add_b, add_sum;

    logic         accept, slot_free, emit_more, out_load;
    logic [31:0]  base_eff, acc_eff, acc_new;
    logic [2:0]   idx_eff, idx_new;
    logic         over_eff, over_new;

    // Place a 7-bit group at its position in the word; fifth group loses its top bits
    function automatic logic [31:0] place_group(input logic [6:0] g, input logic [2:0] idx);
        logic [31:0] w;
        w = '0;
        unique case (idx)
            3'd0:    w = {25'b0, g};
            3'd1:    w = {18'b0, g, 7'b0};
            3'd2:    w = {11'b0, g, 14'b0};
            3'd3:    w = {4'b0, g, 21'b0};
            3'd4:    w = {g[3:0], 28'b0};
            default: w = '0;
        endcase
        return w;
    endfunction

    vdc_serial_add u_add (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (add_req),
        .op_a    (add_a),
        .op_b    (add_b),
        .sum     (add_sum),
        .sts     (add_sts)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_valid_reg || m_tready;
    assign emit_more = |work_reg[31:vdc_pkg::GROUP_W];
    assign out_load  = slot_free && ((state_reg == S_EMIT) || (state_reg == S_OUT));

    // Start flag clears the delta base and any unfinished code
    assign base_eff = s_tuser ? '0 : base_reg;
    assign acc_eff  = s_tuser ? '0 : acc_reg;
    assign idx_eff  = s_tuser ? '0 : idx_reg;
    assign over_eff = s_tuser ? 1'b0 : over_reg;

    // Gather the incoming group or flag an overlong code
    always_comb begin
        if (idx_eff < vdc_pkg::MAX_GROUPS) begin
            acc_new  = acc_eff | place_group(s_tdata[6:0], idx_eff);
            idx_new  = idx_eff + 3'd1;
            over_new = over_eff;
        end else begin
            acc_new  = acc_eff;
            idx_new  = idx_eff;
            over_new = 1'b1;
        end
    end

    always_comb begin
        state_next     = state_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        idx_next       = idx_reg;
        over_next      = over_reg;
        pend_over_next = pend_over_reg;
        work_next      = work_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;
        m_over_next    = m_over_reg;
        add_req.start  = 1'b0;
        add_req.sub    = 1'b0;
        add_a          = s_tdata;
        add_b          = delta_en_reg ? base_eff : '0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (!decode_mode_reg) begin
                        // Encode: difference against the previous value when delta coding is on, else against zero
                        add_req.start = 1'b1;
                        add_req.sub   = 1'b1;
                        base_next     = s_tdata;
                        state_next    = S_ARITH;
                    end else begin
                        base_next = base_eff;
                        if (s_tdata[7]) begin
                            // Continuation byte: hold the partial code
                            acc_next  = acc_new;
                            idx_next  = idx_new;
                            over_next = over_new;
                        end else begin
                            // Final byte: add the running sum
                            add_req.start  = 1'b1;
                            add_a          = acc_new;
                            pend_over_next = over_new;
                            acc_next       = '0;
                            idx_next       = '0;
                            over_next      = 1'b0;
                            state_next     = S_ARITH;
                        end
                    end
                end
            end
            S_ARITH: begin
                if (add_sts.done) begin
                    work_next  = add_sum;
                    state_next = decode_mode_reg ? S_OUT : S_EMIT;
                end
            end
            S_EMIT: begin
                // Emit one group per beat, low group first
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {24'b0, emit_more, work_reg[6:0]};
                    m_last_next  = !emit_more;
                    m_over_next  = 1'b0;
                    work_next    = work_reg >> vdc_pkg::GROUP_W;
                    if (!emit_more) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_OUT: begin
                // Emit the decoded value and keep it as the next base
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = work_reg;
                    m_last_next  = 1'b1;
                    m_over_next  = pend_over_reg;
                    base_next    = work_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            decode_mode_reg <= 1'b0;
            delta_en_reg    <= 1'b0;
            base_reg        <= '0;
            acc_reg         <= '0;
            idx_reg         <= '0;
            over_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            base_reg    <= base_next;
            acc_reg     <= acc_next;
            idx_reg     <= idx_next;
            over_reg    <= over_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    vdc_pkg::CFG_DECODE_MODE:  decode_mode_reg <= cfg_wdata;
                    vdc_pkg::CFG_DELTA_ENABLE: delta_en_reg    <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pend_over_reg <= pend_over_next;
        work_reg      <= work_next;
        m_data_reg    <= m_data_next;
        m_last_reg    <= m_last_next;
        m_over_reg    <= m_over_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_over_reg;

    // Adder finishes only while the sequencer waits on it
    `VDC_ASSERT_NOW(a_done_in_arith, aclk, aresetn, add_sts.done, state_reg == S_ARITH)
    // No input is taken while the adder is running
    `VDC_ASSERT_NOW(a_idle_adder, aclk, aresetn, s_tready, !add_sts.busy)
    // Last byte of an encoded value returns the sequencer to idle
    `VDC_ASSERT_NEXT(a_emit_end, aclk, aresetn, out_load && (state_reg == S_EMIT) && !emit_more,
                     state_reg == S_IDLE)
    // Overlong flag only rides on a final beat
    `VDC_ASSERT_NOW(a_over_last, aclk, aresetn, m_valid_reg && m_over_reg, m_last_reg)

endmodule

>>> dv/tb_varint_delta_codec_unit.sv
`timescale 1ns / 1ps

module tb_varint_delta_codec_unit;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;
    localparam logic DELTA_OFF   = 1'b0;
    localparam logic DELTA_ON    = 1'b1;

    localparam logic [31:0] GROUP_MASK = 32'h0000_007f;
    localparam logic [7:0]  CONT_BIT   = 8'h80;

    // settle margin for the slowest item: a final decode byte or a five-byte encode
    localparam int SETTLE_CYCLES = 16;

    // Mirror of the codec state; holds the byte or value beats still owed
    class codec_scoreboard;
        typedef struct packed {
            logic [31:0] data;
            logic        last;
            logic        overlong;
        } codec_beat_t;

        codec_beat_t owed_beats[$];
        logic        decode_mode;
        logic        delta_on;
        logic [31:0] run_base;
        logic [31:0] accum;
        logic [2:0]  groups;
        logic        overlong_seen;
        int          errors;

        function new();
            decode_mode   = MODE_ENCODE;
            delta_on      = DELTA_OFF;
            run_base      = '0;
            accum         = '0;
            groups        = '0;
            overlong_seen = 1'b0;
            errors        = 0;
        endfunction

        function void write_reg(logic idx, logic val);
            if (idx == vdc_pkg::CFG_DECODE_MODE) begin
                decode_mode = val;
            end else begin
                delta_on = val;
            end
        endfunction

        // Work out the beats one accepted input causes
        function void note_input(logic [31:0] din, logic start);
            logic [31:0] v;
            logic [7:0]  b;
            if (start) begin
                run_base = '0;
            end
            if (decode_mode == MODE_ENCODE) begin
                v = delta_on ? din - run_base : din;
                run_base = din;
                while (v > GROUP_MASK) begin
                    owed_beats.push_back('{(v & GROUP_MASK) | {24'h0, CONT_BIT}, 1'b0, 1'b0});
                    v = v >> vdc_pkg::GROUP_W;
                end
                owed_beats.push_back('{v, 1'b1, 1'b0});
            end else begin
                if (start) begin
                    accum         = '0;
                    groups        = '0;
                    overlong_seen = 1'b0;
                end
                b = din[7:0];
                // groups past the fifth are dropped and flagged
                if (groups < vdc_pkg::MAX_GROUPS) begin
                    accum  = accum | ({25'h0, b[6:0]} << (vdc_pkg::GROUP_W * groups));
                    groups = groups + 3'd1;
                end else begin
                    overlong_seen = 1'b1;
                end
                if ((b & CONT_BIT) == 8'h00) begin
                    v = delta_on ? accum + run_base : accum;
                    run_base = v;
                    owed_beats.push_back('{v, 1'b1, overlong_seen});
                    accum         = '0;
                    groups        = '0;
                    overlong_seen = 1'b0;
                end
            end
        endfunction

        // Compare one output beat against the oldest owed beat
        function void check_result(logic [31:0] dout, logic last, logic ovl);
            codec_beat_t exp_beat;
            if (owed_beats.size() == 0) begin
                $display("%0t: unexpected beat: data %h last %b overlong %b",
                         $time, dout, last, ovl);
                errors++;
                return;
            end
            exp_beat = owed_beats.pop_front();
            if (dout !== exp_beat.data) begin
                $display("%0t: m_tdata mismatch: expected %h, actual %h",
                         $time, exp_beat.data, dout);
                errors++;
            end
            if (last !== exp_beat.last) begin
                $display("%0t: m_tlast mismatch: expected %b, actual %b",
                         $time, exp_beat.last, last);
                errors++;
            end
            if (ovl !== exp_beat.overlong) begin
                $display("%0t: m_tuser mismatch: expected %b, actual %b",
                         $time, exp_beat.overlong, ovl);
                errors++;
            end
        endfunction

        function int outstanding();
            return owed_beats.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [31:0] in_data
    logic        s_tuser = 1'b0; // [0] start_of_run
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // [31:0] out_data
    logic        m_tlast;
    logic        m_tuser;        // [0] overlong

    codec_scoreboard sb = new();

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_stall = 0;

    varint_delta_codec_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // End the run if the block hangs
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Stall the output side in random bursts
    always @(negedge aclk) begin
        if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_tready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 6) == 0) begin
            rx_stall <= $urandom_range(1, 17) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Check every accepted output beat
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            sb.check_result(m_tdata, m_tlast, m_tuser);
        end
    end

    // Present one beat, with an occasional gap ahead of it; hold until accepted
    task automatic push_item(input logic [31:0] din, input logic start);
        int gap;
        @(negedge aclk);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 17);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = din;
        s_tuser  = start;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(din, start);
    endtask

    // Drop valid and wait until every owed beat has come out
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
    endtask

    // Drain, then let a code still in flight settle
    task automatic quiesce();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic idx, input logic val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Values spread over every code length
    function automatic logic [31:0] random_value();
        return $urandom >> $urandom_range(0, 32);
    endfunction

    // Byte in the low bits, random junk above half the time
    function automatic logic [31:0] byte_word(logic [7:0] b);
        return ($urandom_range(0, 1) ? ($urandom & 32'hffff_ff00) : 32'h0) | {24'h0, b};
    endfunction

    // Send one encoded value as bytes, or an overlong code of random groups
    task automatic send_code(input logic [31:0] value, input bit too_long,
                             output int n_bytes);
        logic [31:0] v;
        logic        start;
        int          len;
        start   = ($urandom_range(0, 5) == 0);
        v       = value;
        n_bytes = 0;
        if (too_long) begin
            len = $urandom_range(6, 8);
            for (int i = 0; i < len; i++) begin
                push_item(byte_word({(i < len - 1), 7'($urandom)}), start && i == 0);
            end
            n_bytes = len;
        end else begin
            while (v > GROUP_MASK) begin
                push_item(byte_word(v[7:0] | CONT_BIT), start && n_bytes == 0);
                v = v >> vdc_pkg::GROUP_W;
                n_bytes++;
            end
            push_item(byte_word(v[7:0]), start && n_bytes == 0);
            n_bytes++;
        end
    endtask

    // One setting, mostly well-formed traffic, one full drain halfway
    task automatic random_segment(input logic mode, input logic delta,
                                  input bit tx_idl, input bit rx_idl, input int n_items);
        int sent;
        int kind;
        int n;
        bit paused;
        quiesce();
        write_cfg(vdc_pkg::CFG_DECODE_MODE, mode);
        write_cfg(vdc_pkg::CFG_DELTA_ENABLE, delta);
        tx_idle_on = tx_idl;
        rx_idle_on = rx_idl;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            if (!paused && sent >= n_items / 2) begin
                paused = 1'b1;
                drain_results();
            end
            if (mode == MODE_ENCODE) begin
                kind = $urandom_range(0, 9);
                push_item(kind == 0 ? 32'hffff_ffff : random_value(),
                          $urandom_range(0, 7) == 0);
                sent++;
            end else begin
                kind = $urandom_range(0, 9);
                if (kind < 7) begin
                    send_code(random_value(), 1'b0, n);
                end else if (kind < 8) begin
                    send_code('0, 1'b1, n);
                end else begin
                    // noise: random byte, random start
                    push_item($urandom, $urandom_range(0, 3) == 0);
                    n = 1;
                end
                sent += n;
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        write_cfg(vdc_pkg::CFG_DECODE_MODE, MODE_ENCODE);
        write_cfg(vdc_pkg::CFG_DELTA_ENABLE, DELTA_OFF);
        // group boundaries and the full word
        push_item(32'h0000_0000, 1'b1);
        push_item(32'h0000_007f, 1'b0);
        push_item(32'h0000_0080, 1'b0);
        push_item(32'hffff_ffff, 1'b0);

        // a falling value wraps to a five-byte difference
        quiesce();
        write_cfg(vdc_pkg::CFG_DELTA_ENABLE, DELTA_ON);
        push_item(32'h0000_0005, 1'b1);
        push_item(32'h0000_0003, 1'b0);

        quiesce();
        write_cfg(vdc_pkg::CFG_DECODE_MODE, MODE_DECODE);
        write_cfg(vdc_pkg::CFG_DELTA_ENABLE, DELTA_OFF);
        push_item(32'h0000_0000, 1'b0);
        // five-byte code, top bits of the fifth group fall off
        repeat (4) push_item(32'h0000_00ff, 1'b0);
        push_item(32'h0000_007f, 1'b0);
        // sixth group is dropped and flagged
        repeat (5) push_item(32'h0000_0080, 1'b0);
        push_item(32'h0000_0001, 1'b0);
        // upper word bits ignored; start discards an unfinished code
        push_item(32'habcd_ef85, 1'b0);
        push_item(32'h1234_5603, 1'b1);
        // leave a code open across a trip through encode mode
        push_item(32'h0000_0081, 1'b0);
        quiesce();
        write_cfg(vdc_pkg::CFG_DECODE_MODE, MODE_ENCODE);
        push_item(32'h0000_3fff, 1'b0);
        quiesce();
        write_cfg(vdc_pkg::CFG_DECODE_MODE, MODE_DECODE);
        push_item(32'h0000_0002, 1'b0);
        // running sum against the last decoded value
        quiesce();
        write_cfg(vdc_pkg::CFG_DELTA_ENABLE, DELTA_ON);
        push_item(32'h0000_007f, 1'b0);

        random_segment(MODE_ENCODE, DELTA_OFF, 1'b1, 1'b1, 40);
        random_segment(MODE_DECODE, DELTA_ON,  1'b1, 1'b1, 40);
        random_segment(MODE_ENCODE, DELTA_ON,  1'b1, 1'b0, 35);
        random_segment(MODE_DECODE, DELTA_OFF, 1'b0, 1'b1, 40);
        random_segment(MODE_DECODE, DELTA_ON,  1'b0, 1'b0, 40);
        random_segment(MODE_ENCODE, DELTA_ON,  1'b0, 1'b0, 35);

        quiesce();
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
